>>> rtl/core/nfp_pkg.sv
// nfp_pkg: shared types, codes and helpers for the navigation frame parser
// no dependencies; used by nfp_front, nfp_queue, nfp_back and nav_frame_parser
`default_nettype none

package nfp_pkg;

  // record kinds
  localparam logic [2:0] KIND_HEADER = 3'd0;
  localparam logic [2:0] KIND_POINT  = 3'd1;
  localparam logic [2:0] KIND_MARK   = 3'd2;
  localparam logic [2:0] KIND_STUB   = 3'd3;
  localparam logic [2:0] KIND_NAME   = 3'd4;
  localparam logic [2:0] KIND_STATUS = 3'd5;

  // frame status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_SHORT     = 2'd1;
  localparam logic [1:0] STAT_BAD_VER   = 2'd2;
  localparam logic [1:0] STAT_TRUNCATED = 2'd3;

  // configuration register map, decoded on paddr[2]
  localparam int unsigned CFG_AW = 3;
  localparam logic REG_EXP_VERSION  = 1'b0;
  localparam logic REG_FALLBACK_MRK = 1'b1;
  localparam logic [7:0] EXP_VERSION_RST = 8'd4;

  // header byte positions
  localparam logic [3:0] HDR_VERSION = 4'd0;
  localparam logic [3:0] HDR_FLAGS   = 4'd1;
  localparam logic [3:0] HDR_MANEUV  = 4'd2;
  localparam logic [3:0] HDR_DIST_LO = 4'd3;
  localparam logic [3:0] HDR_DIST_HI = 4'd4;
  localparam logic [3:0] HDR_SPD_LO  = 4'd5;
  localparam logic [3:0] HDR_SPD_HI  = 4'd6;
  localparam logic [3:0] HDR_ETA_LO  = 4'd7;
  localparam logic [3:0] HDR_ETA_HI  = 4'd8;
  localparam logic [3:0] HDR_REM_LO  = 4'd9;
  localparam logic [3:0] HDR_REM_HI  = 4'd10;
  localparam logic [3:0] HDR_COUNT   = 4'd11;

  // element sizes in bytes, as last byte position
  localparam logic [3:0] PT_LAST   = 4'd3;
  localparam logic [3:0] MARK_LAST = 4'd4;
  localparam logic [3:0] STUB_LAST = 4'd5;
  localparam int unsigned ITEM_BYTES = 6;

  // decoupling queue
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PW    = $clog2(Q_DEPTH);
  localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [5:0]         index;
    logic signed [15:0] x_cm;
    logic signed [15:0] y_cm;
    logic [7:0]         aux_a;
    logic [7:0]         aux_b;
    logic [15:0]        distance_m;
    logic [15:0]        speed_kmh_x10;
    logic [15:0]        eta_s;
    logic [19:0]        remaining_m;
    logic [1:0]         status;
    logic               last_of_run;
  } out_item_t;

  // one classified byte: an optional record and an optional frame status
  typedef struct packed {
    logic       has_rec;
    logic       has_stat;
    logic [1:0] stat;
    out_item_t  rec;
  } q_entry_t;

  function automatic logic [5:0] clamp_cnt(input logic [7:0] b, input logic [5:0] lim);
    logic [5:0] r;
    r = (b > {2'b00, lim}) ? lim : b[5:0];
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/nfp_front.sv
// nfp_front: byte-level frame parser, turns each accepted byte that yields a record or a status into a queue entry
// depends on nfp_pkg
`default_nettype none

module nfp_front #(
  parameter int unsigned MAX_POINTS     = 32,
  parameter int unsigned MAX_MARKS      = 8,
  parameter int unsigned MAX_STUBS      = 8,
  parameter int unsigned MAX_NAME_BYTES = 32,
  parameter int unsigned MANEUVER_KINDS = 16,
  parameter int unsigned MARK_KINDS     = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              take,
  input  wire nfp_pkg::in_item_t in_data,
  input  wire logic [7:0]        exp_version,
  input  wire logic [7:0]        fallback_type,
  output logic                   push,
  output nfp_pkg::q_entry_t      entry
);

  typedef enum logic [7:0] {
    SEC_HEADER  = 8'b0000_0001,
    SEC_POINTS  = 8'b0000_0010,
    SEC_MARKCNT = 8'b0000_0100,
    SEC_MARKS   = 8'b0000_1000,
    SEC_STUBCNT = 8'b0001_0000,
    SEC_STUBS   = 8'b0010_0000,
    SEC_NAMELEN = 8'b0100_0000,
    SEC_NAME    = 8'b1000_0000
  } sec_t;

  localparam logic [5:0] LIM_PTS  = 6'(MAX_POINTS);
  localparam logic [5:0] LIM_MRK  = 6'(MAX_MARKS);
  localparam logic [5:0] LIM_STB  = 6'(MAX_STUBS);
  localparam logic [5:0] LIM_NAME = 6'(MAX_NAME_BYTES);
  localparam logic [7:0] MAN_KINDS = 8'(MANEUVER_KINDS);
  localparam logic [7:0] MRK_KINDS = 8'(MARK_KINDS);
  localparam int unsigned ITEM_BYTES_L = nfp_pkg::ITEM_BYTES;

  sec_t        sec_r, sec_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [5:0]  eidx_r, eidx_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        vbad_r, vbad_nxt;
  logic        fc_r, fc_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [3:0]  man_r, man_nxt;
  logic [15:0] dist_r, dist_nxt;
  logic [15:0] spd_r, spd_nxt;
  logic [15:0] eta_r, eta_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [7:0]  item_r [ITEM_BYTES_L];
  logic [7:0]  item_nxt [ITEM_BYTES_L];

  logic [7:0]  b;
  logic [7:0]  cb [ITEM_BYTES_L];
  logic        active;
  logic [5:0]  eidx_inc;
  logic [3:0]  last_pos;
  logic [2:0]  el_kind;
  sec_t        el_next;
  logic        enter_req;
  sec_t        enter_sec, enter_skip;
  logic [5:0]  enter_cnt;
  logic        has_rec;
  nfp_pkg::out_item_t rec;
  logic        has_stat;
  logic [1:0]  stat;

  assign b        = in_data.data_byte;
  assign active   = !fc_r && !(vbad_r && (sec_r != SEC_HEADER));
  assign eidx_inc = eidx_r + 6'd1;

  // current element bytes with the incoming byte merged in
  always_comb begin
    for (int i = 0; i < ITEM_BYTES_L; i++) begin
      cb[i] = (pos_r == 4'(i)) ? b : item_r[i];
    end
  end

  always_comb begin
    case (sec_r)
      SEC_POINTS: begin
        last_pos = nfp_pkg::PT_LAST;
        el_kind  = nfp_pkg::KIND_POINT;
        el_next  = SEC_MARKCNT;
      end
      SEC_MARKS: begin
        last_pos = nfp_pkg::MARK_LAST;
        el_kind  = nfp_pkg::KIND_MARK;
        el_next  = SEC_STUBCNT;
      end
      default: begin
        last_pos = nfp_pkg::STUB_LAST;
        el_kind  = nfp_pkg::KIND_STUB;
        el_next  = SEC_NAMELEN;
      end
    endcase
  end

  always_comb begin
    sec_nxt   = sec_r;
    pos_nxt   = pos_r;
    eidx_nxt  = eidx_r;
    cnt_nxt   = cnt_r;
    vbad_nxt  = vbad_r;
    fc_nxt    = fc_r;
    flags_nxt = flags_r;
    man_nxt   = man_r;
    dist_nxt  = dist_r;
    spd_nxt   = spd_r;
    eta_nxt   = eta_r;
    rem_nxt   = rem_r;
    item_nxt  = item_r;
    rec       = '0;
    has_rec   = 1'b0;
    enter_req = 1'b0;
    enter_sec = SEC_POINTS;
    enter_skip = SEC_MARKCNT;
    enter_cnt = '0;
    has_stat  = 1'b0;
    stat      = nfp_pkg::STAT_OK;

    if (take && active) begin
      case (sec_r)
        SEC_HEADER: begin
          case (pos_r)
            nfp_pkg::HDR_VERSION: vbad_nxt = (b != exp_version);
            nfp_pkg::HDR_FLAGS:   flags_nxt = b;
            nfp_pkg::HDR_MANEUV:  man_nxt = (b < MAN_KINDS) ? b[3:0] : 4'd0;
            nfp_pkg::HDR_DIST_LO: dist_nxt[7:0] = b;
            nfp_pkg::HDR_DIST_HI: dist_nxt[15:8] = b;
            nfp_pkg::HDR_SPD_LO:  spd_nxt[7:0] = b;
            nfp_pkg::HDR_SPD_HI:  spd_nxt[15:8] = b;
            nfp_pkg::HDR_ETA_LO:  eta_nxt[7:0] = b;
            nfp_pkg::HDR_ETA_HI:  eta_nxt[15:8] = b;
            nfp_pkg::HDR_REM_LO:  rem_nxt[7:0] = b;
            nfp_pkg::HDR_REM_HI:  rem_nxt[15:8] = b;
            default: ;
          endcase
          if (pos_r >= nfp_pkg::HDR_COUNT) begin
            if (!vbad_r) begin
              has_rec            = 1'b1;
              rec.kind           = nfp_pkg::KIND_HEADER;
              rec.index          = nfp_pkg::clamp_cnt(b, LIM_PTS);
              rec.aux_a          = {4'd0, man_r};
              rec.aux_b          = flags_r;
              rec.distance_m     = dist_r;
              rec.speed_kmh_x10  = spd_r;
              rec.eta_s          = eta_r;
              // times ten as 8x + 2x
              rec.remaining_m    = {1'b0, rem_r, 3'b000} + {3'b000, rem_r, 1'b0};
            end
            enter_req  = 1'b1;
            enter_sec  = SEC_POINTS;
            enter_skip = SEC_MARKCNT;
            enter_cnt  = nfp_pkg::clamp_cnt(b, LIM_PTS);
          end else begin
            pos_nxt = pos_r + 4'd1;
          end
        end
        SEC_MARKCNT: begin
          enter_req  = 1'b1;
          enter_sec  = SEC_MARKS;
          enter_skip = SEC_STUBCNT;
          enter_cnt  = nfp_pkg::clamp_cnt(b, LIM_MRK);
        end
        SEC_STUBCNT: begin
          enter_req  = 1'b1;
          enter_sec  = SEC_STUBS;
          enter_skip = SEC_NAMELEN;
          enter_cnt  = nfp_pkg::clamp_cnt(b, LIM_STB);
        end
        SEC_NAMELEN: begin
          enter_req  = 1'b1;
          enter_sec  = SEC_NAME;
          enter_skip = SEC_NAME;
          enter_cnt  = nfp_pkg::clamp_cnt(b, LIM_NAME);
        end
        SEC_NAME: begin
          has_rec   = 1'b1;
          rec.kind  = nfp_pkg::KIND_NAME;
          rec.index = eidx_r;
          rec.aux_a = b;
          eidx_nxt  = eidx_inc;
          if (eidx_inc >= cnt_r) begin
            fc_nxt = 1'b1;
          end
        end
        default: begin
          if (pos_r < 4'(ITEM_BYTES_L)) begin
            item_nxt[pos_r[2:0]] = b;
          end
          if (pos_r >= last_pos) begin
            has_rec   = 1'b1;
            rec.kind  = el_kind;
            rec.index = eidx_r;
            rec.x_cm  = {cb[1], cb[0]};
            rec.y_cm  = {cb[3], cb[2]};
            if (el_kind == nfp_pkg::KIND_MARK) begin
              rec.aux_a = (cb[4] < MRK_KINDS) ? cb[4] : fallback_type;
            end else if (el_kind == nfp_pkg::KIND_STUB) begin
              rec.aux_a = cb[4];
              rec.aux_b = cb[5];
            end
            pos_nxt  = '0;
            eidx_nxt = eidx_inc;
            if (eidx_inc >= cnt_r) begin
              sec_nxt  = el_next;
              eidx_nxt = '0;
            end
          end else begin
            pos_nxt = pos_r + 4'd1;
          end
        end
      endcase
    end

    // start a counted section, an empty one falls through
    if (enter_req) begin
      pos_nxt  = '0;
      eidx_nxt = '0;
      cnt_nxt  = enter_cnt;
      if (enter_cnt != 6'd0) begin
        sec_nxt = enter_sec;
      end else begin
        sec_nxt = enter_skip;
        if (enter_sec == SEC_NAME) begin
          fc_nxt = 1'b1;
        end
      end
    end

    // frame end: status from the updated state, then back to the start
    if (take && in_data.frame_end) begin
      has_stat = 1'b1;
      if (sec_nxt == SEC_HEADER) begin
        stat = nfp_pkg::STAT_SHORT;
      end else if (vbad_nxt) begin
        stat = nfp_pkg::STAT_BAD_VER;
      end else if (!fc_nxt) begin
        stat = nfp_pkg::STAT_TRUNCATED;
      end else begin
        stat = nfp_pkg::STAT_OK;
      end
      sec_nxt  = SEC_HEADER;
      pos_nxt  = '0;
      eidx_nxt = '0;
      cnt_nxt  = '0;
      vbad_nxt = 1'b0;
      fc_nxt   = 1'b0;
    end
  end

  assign push           = has_rec || has_stat;
  assign entry.has_rec  = has_rec;
  assign entry.has_stat = has_stat;
  assign entry.stat     = stat;
  assign entry.rec      = rec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r  <= SEC_HEADER;
      pos_r  <= '0;
      eidx_r <= '0;
      cnt_r  <= '0;
      vbad_r <= 1'b0;
      fc_r   <= 1'b0;
    end else begin
      sec_r  <= sec_nxt;
      pos_r  <= pos_nxt;
      eidx_r <= eidx_nxt;
      cnt_r  <= cnt_nxt;
      vbad_r <= vbad_nxt;
      fc_r   <= fc_nxt;
    end
  end

  // header fields and element bytes are always written before they are read
  always_ff @(posedge clk) begin
    flags_r <= flags_nxt;
    man_r   <= man_nxt;
    dist_r  <= dist_nxt;
    spd_r   <= spd_nxt;
    eta_r   <= eta_nxt;
    rem_r   <= rem_nxt;
    item_r  <= item_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/core/nfp_queue.sv
// nfp_queue: small register queue of classified entries between front and back
// depends on nfp_pkg
`default_nettype none

module nfp_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire nfp_pkg::q_entry_t wr_entry,
  input  wire logic              pop,
  output nfp_pkg::q_entry_t      rd_entry,
  output logic                   full,
  output logic                   empty
);

  localparam int unsigned DEPTH = nfp_pkg::Q_DEPTH;
  localparam int unsigned PW    = nfp_pkg::Q_PW;
  localparam int unsigned CW    = nfp_pkg::Q_CW;

  nfp_pkg::q_entry_t mem_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign rd_entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/nfp_back.sv
// nfp_back: expands queue entries into result transfers through an output register
// depends on nfp_pkg
`default_nettype none

module nfp_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire nfp_pkg::q_entry_t head,
  input  wire logic              head_valid,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output nfp_pkg::out_item_t     out_data
);

  logic               valid_r, valid_nxt;
  logic               phase_r, phase_nxt;
  nfp_pkg::out_item_t data_r, data_nxt;
  logic               load;

  // record first, then the status if the byte closed the frame
  assign load = head_valid && (!valid_r || out_ready);

  always_comb begin
    valid_nxt = valid_r;
    phase_nxt = phase_r;
    data_nxt  = data_r;
    pop       = 1'b0;
    if (valid_r && out_ready) begin
      valid_nxt = 1'b0;
    end
    if (load) begin
      valid_nxt = 1'b1;
      if (head.has_rec && !phase_r) begin
        data_nxt             = head.rec;
        data_nxt.last_of_run = !head.has_stat;
        if (head.has_stat) begin
          phase_nxt = 1'b1;
        end else begin
          pop = 1'b1;
        end
      end else begin
        data_nxt             = '0;
        data_nxt.kind        = nfp_pkg::KIND_STATUS;
        data_nxt.status      = head.stat;
        data_nxt.last_of_run = 1'b1;
        phase_nxt            = 1'b0;
        pop                  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

>>> rtl/core/nav_frame_parser.sv
// nav_frame_parser: top level, config registers, front parser, queue and result stage
// depends on nfp_pkg, nfp_front, nfp_queue, nfp_back
`default_nettype none

// Streaming decoder for one navigation frame, one byte per input transfer with
// frame_end set on the last byte. The front parser takes a byte every cycle
// while the four-entry queue has room; it checks the version byte against
// expected_version, collects the 12-byte little-endian header and then the
// points, landmarks, branches and street name, each count clamped to its
// parameter. A byte that completes a record yields one result transfer; the
// frame_end byte adds a status transfer (accepted, too short, bad version,
// truncated), so a byte yields zero, one or two results, last_of_run marking
// the final one. The result stage drains one entry per cycle while out_ready
// allows, sending an entry with both a record and a status as two transfers,
// so sustained input rate is one byte per cycle except around frame ends and
// result stalls. Downstream should commit the records of a frame only on an
// accepted status. Registers sit on an APB-style port: expected_version at 0x0
// (reset 4), fallback_landmark_type at 0x4 (reset 0); write them only while idle.
module nav_frame_parser #(
  parameter int unsigned MAX_POINTS     = 32,
  parameter int unsigned MAX_MARKS      = 8,
  parameter int unsigned MAX_STUBS      = 8,
  parameter int unsigned MAX_NAME_BYTES = 32,
  parameter int unsigned MANEUVER_KINDS = 16,
  parameter int unsigned MARK_KINDS     = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // byte input channel
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire nfp_pkg::in_item_t          in_data,
  // result channel
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output nfp_pkg::out_item_t              out_data,
  // configuration port
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [nfp_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  // config registers
  logic [7:0] exp_version_r;
  logic [7:0] fallback_r;
  logic       cfg_wr;

  // front to queue to back
  logic              take;
  logic              q_push;
  nfp_pkg::q_entry_t q_wr_entry;
  nfp_pkg::q_entry_t q_head;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // word-aligned decode on address bit 2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_version_r <= nfp_pkg::EXP_VERSION_RST;
      fallback_r    <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == nfp_pkg::REG_EXP_VERSION) begin
        exp_version_r <= pwdata[7:0];
      end else begin
        fallback_r <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == nfp_pkg::REG_FALLBACK_MRK) begin
      prdata = {24'd0, fallback_r};
    end else begin
      prdata = {24'd0, exp_version_r};
    end
  end

  // a byte transfer completes whenever the queue has room
  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  nfp_front #(
    .MAX_POINTS     (MAX_POINTS),
    .MAX_MARKS      (MAX_MARKS),
    .MAX_STUBS      (MAX_STUBS),
    .MAX_NAME_BYTES (MAX_NAME_BYTES),
    .MANEUVER_KINDS (MANEUVER_KINDS),
    .MARK_KINDS     (MARK_KINDS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .take          (take),
    .in_data       (in_data),
    .exp_version   (exp_version_r),
    .fallback_type (fallback_r),
    .push          (q_push),
    .entry         (q_wr_entry)
  );

  nfp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (q_wr_entry),
    .pop      (q_pop),
    .rd_entry (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // result stage, one output transfer per cycle while out_ready allows
  nfp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .head_valid (!q_empty),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

`ifndef SYNTHESIS
  // front never pushes into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("push into full queue");

  // back only pops a present entry
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("pop from empty queue");

  // a status always closes the run of its byte
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.kind == nfp_pkg::KIND_STATUS)) |-> out_data.last_of_run)
    else $error("status without last_of_run");

  // only status transfers carry a non-zero status field
  a_rec_stat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.kind != nfp_pkg::KIND_STATUS)) |->
    (out_data.status == nfp_pkg::STAT_OK)) else $error("status on record");
`endif

endmodule

`default_nettype wire

>>> tb/sv/nav_frame_parser_tb.sv
// nav_frame_parser_tb: self-checking testbench for the navigation frame parser
// drives byte frames and register writes, predicts every record and status
// depends on nfp_pkg and nav_frame_parser
module nav_frame_parser_tb;
  import nfp_pkg::*;

  localparam int unsigned MAX_POINTS     = 32;
  localparam int unsigned MAX_MARKS      = 8;
  localparam int unsigned MAX_STUBS      = 8;
  localparam int unsigned MAX_NAME_BYTES = 32;
  localparam int unsigned MANEUVER_KINDS = 16;
  localparam int unsigned MARK_KINDS     = 8;

  // parse sections of one frame, in stream order
  localparam logic [2:0] ST_HEADER   = 3'd0;
  localparam logic [2:0] ST_POINTS   = 3'd1;
  localparam logic [2:0] ST_MARK_CNT = 3'd2;
  localparam logic [2:0] ST_MARKS    = 3'd3;
  localparam logic [2:0] ST_STUB_CNT = 3'd4;
  localparam logic [2:0] ST_STUBS    = 3'd5;
  localparam logic [2:0] ST_NAME_LEN = 3'd6;
  localparam logic [2:0] ST_NAME     = 3'd7;

  localparam int PHASE_ITEMS = 140;  // live bytes per random phase
  localparam int HOLD_CYCLES = 300;  // long receiver back-pressure
  localparam int MAX_PRINTS  = 200;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  nav_frame_parser #(
    .MAX_POINTS(MAX_POINTS),
    .MAX_MARKS(MAX_MARKS),
    .MAX_STUBS(MAX_STUBS),
    .MAX_NAME_BYTES(MAX_NAME_BYTES),
    .MANEUVER_KINDS(MANEUVER_KINDS),
    .MARK_KINDS(MARK_KINDS)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // frame decoder model: register copies and parse state
  // ---------------------------------------------------------------------------
  logic [7:0]  cfg_version;
  logic [7:0]  cfg_fallback;

  logic [2:0]  prs_sec;
  logic [3:0]  prs_pos;
  logic [5:0]  prs_idx;
  logic [5:0]  prs_cnt;
  logic        prs_badver;
  logic [7:0]  prs_flags;
  logic [3:0]  prs_maneuver;
  logic [15:0] prs_words [4];          // distance, speed, eta, remaining decametres
  logic [7:0]  prs_elem [ITEM_BYTES];  // bytes of the element being collected
  logic        prs_done;

  out_item_t   decoded [2];            // records caused by the latest byte
  out_item_t   pending_recs [$];       // records still owed by the block
  out_item_t   want_rec;
  logic [7:0]  frame_q [$];            // bytes of the frame being sent

  int          mismatches;
  int          live_items;             // bytes the parser actually acts on
  int          tx_calm;
  bit          hold_req;

  function automatic void clear_parse();
    prs_sec      = ST_HEADER;
    prs_pos      = 4'd0;
    prs_idx      = 6'd0;
    prs_cnt      = 6'd0;
    prs_badver   = 1'b0;
    prs_flags    = 8'd0;
    prs_maneuver = 4'd0;
    for (int i = 0; i < 4; i++) prs_words[i] = 16'd0;
    for (int i = 0; i < ITEM_BYTES; i++) prs_elem[i] = 8'd0;
    prs_done     = 1'b0;
  endfunction

  function automatic logic [5:0] cap_count(input logic [7:0] raw, input int unsigned lim);
    return (raw > lim) ? 6'(lim) : raw[5:0];
  endfunction

  // start a counted section; an empty one falls through, an empty name ends the frame
  function automatic void open_section(input logic [2:0] nxt, input logic [5:0] cnt);
    prs_pos = 4'd0;
    prs_idx = 6'd0;
    prs_cnt = cnt;
    if (cnt != 6'd0) begin
      prs_sec = nxt;
    end else if (nxt == ST_NAME) begin
      prs_sec  = ST_NAME;
      prs_done = 1'b1;
    end else begin
      prs_sec = nxt + 3'd1;
    end
  endfunction

  // advance the model by one byte; fills decoded[] and returns how many records
  function automatic int decode_byte(input logic [7:0] b, input logic fin);
    out_item_t  r;
    int         n;
    int         w;
    int         sz;
    logic [3:0] p;
    logic [2:0] k;
    logic [5:0] c;
    n = 0;
    r = '0;
    sz = 0;
    k = KIND_POINT;
    if (!prs_done && !(prs_badver && prs_sec != ST_HEADER)) begin
      p = prs_pos;
      case (prs_sec)
        ST_HEADER: begin
          if (p == HDR_VERSION) begin
            prs_badver = (b != cfg_version);
          end else if (p == HDR_FLAGS) begin
            prs_flags = b;
          end else if (p == HDR_MANEUV) begin
            // unknown maneuver collapses to straight
            prs_maneuver = (b < MANEUVER_KINDS) ? b[3:0] : 4'd0;
          end else if (p <= HDR_REM_HI) begin
            w = (int'(p) - int'(HDR_DIST_LO)) / 2;
            if (p[0]) prs_words[w][7:0] = b;
            else prs_words[w][15:8] = b;
          end
          if (p >= HDR_COUNT) begin
            c = cap_count(b, MAX_POINTS);
            if (!prs_badver) begin
              r.kind          = KIND_HEADER;
              r.index         = c;
              r.aux_a         = {4'd0, prs_maneuver};
              r.aux_b         = prs_flags;
              r.distance_m    = prs_words[0];
              r.speed_kmh_x10 = prs_words[1];
              r.eta_s         = prs_words[2];
              r.remaining_m   = {4'd0, prs_words[3]} * 20'd10;
              decoded[n] = r;
              n++;
            end
            open_section(ST_POINTS, c);
          end else begin
            prs_pos = p + 4'd1;
          end
        end
        ST_MARK_CNT: open_section(ST_MARKS, cap_count(b, MAX_MARKS));
        ST_STUB_CNT: open_section(ST_STUBS, cap_count(b, MAX_STUBS));
        ST_NAME_LEN: open_section(ST_NAME, cap_count(b, MAX_NAME_BYTES));
        ST_NAME: begin
          r.kind  = KIND_NAME;
          r.index = prs_idx;
          r.aux_a = b;
          decoded[n] = r;
          n++;
          prs_idx = prs_idx + 6'd1;
          if (prs_idx >= prs_cnt) prs_done = 1'b1;
        end
        default: begin
          if (prs_sec == ST_POINTS) begin
            sz = int'(PT_LAST) + 1;
            k  = KIND_POINT;
          end else if (prs_sec == ST_MARKS) begin
            sz = int'(MARK_LAST) + 1;
            k  = KIND_MARK;
          end else begin
            sz = int'(STUB_LAST) + 1;
            k  = KIND_STUB;
          end
          if (p < ITEM_BYTES) prs_elem[p] = b;
          p = p + 4'd1;
          if (p >= sz) begin
            r.kind  = k;
            r.index = prs_idx;
            r.x_cm  = {prs_elem[1], prs_elem[0]};
            r.y_cm  = {prs_elem[3], prs_elem[2]};
            if (k == KIND_MARK) begin
              r.aux_a = (prs_elem[4] < MARK_KINDS) ? prs_elem[4] : cfg_fallback;
            end else if (k == KIND_STUB) begin
              r.aux_a = prs_elem[4];
              r.aux_b = prs_elem[5];
            end
            decoded[n] = r;
            n++;
            prs_pos = 4'd0;
            prs_idx = prs_idx + 6'd1;
            if (prs_idx >= prs_cnt) begin
              prs_sec = prs_sec + 3'd1;
              prs_idx = 6'd0;
            end
          end else begin
            prs_pos = p;
          end
        end
      endcase
    end
    if (fin) begin
      // short beats bad version, which beats truncated
      r = '0;
      r.kind = KIND_STATUS;
      if (prs_sec == ST_HEADER) r.status = STAT_SHORT;
      else if (prs_badver) r.status = STAT_BAD_VER;
      else if (!prs_done) r.status = STAT_TRUNCATED;
      else r.status = STAT_OK;
      decoded[n] = r;
      n++;
      clear_parse();
    end
    if (n > 0) decoded[n-1].last_of_run = 1'b1;
    return n;
  endfunction

  // ---------------------------------------------------------------------------
  // random helpers
  // ---------------------------------------------------------------------------
  // mostly short idles, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // byte biased toward the sign and range edges of 16-bit coordinates
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h7F;
      3: return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  // count byte, then the elements it calls for; a few counts overflow the clamp
  function automatic void add_section(input int few, input int unsigned lim, input int sz);
    int unsigned raw;
    int unsigned cnt;
    raw = ($urandom_range(0, 99) < 5) ? $urandom_range(0, 255) : $urandom_range(0, few);
    frame_q.push_back(8'(raw));
    cnt = (raw > lim) ? lim : raw;
    for (int i = 0; i < cnt * sz; i++) begin
      if (sz == int'(MARK_LAST) + 1 && i % sz == sz - 1 && $urandom_range(0, 1))
        frame_q.push_back(8'($urandom_range(0, MARK_KINDS - 1)));
      else
        frame_q.push_back(rand_byte());
    end
  endfunction

  // one frame: mostly well formed, then truncated, bad version, too short and noise
  function automatic void build_frame();
    int shape;
    int n;
    int cut;
    frame_q.delete();
    shape = $urandom_range(0, 99);
    if (shape >= 88) begin
      n = (shape >= 94) ? $urandom_range(1, 40) : $urandom_range(1, 11);
      for (int i = 0; i < n; i++) frame_q.push_back(rand_byte());
      if (shape < 94 && $urandom_range(0, 1)) frame_q[0] = cfg_version;
      return;
    end
    frame_q.push_back((shape >= 76) ? cfg_version ^ 8'($urandom_range(1, 255)) : cfg_version);
    frame_q.push_back(rand_byte());
    frame_q.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : rand_byte());
    for (int i = 0; i < 8; i++) frame_q.push_back(rand_byte());
    add_section(3, MAX_POINTS, int'(PT_LAST) + 1);
    add_section(3, MAX_MARKS, int'(MARK_LAST) + 1);
    add_section(3, MAX_STUBS, int'(STUB_LAST) + 1);
    add_section(6, MAX_NAME_BYTES, 1);
    if (shape >= 56 && shape < 66) begin
      // trailing junk after a complete frame
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) frame_q.push_back(rand_byte());
    end else if (shape >= 66) begin
      // truncated, or bad version with a short ignored tail
      if (shape < 76) cut = $urandom_range(12, frame_q.size() - 1);
      else cut = $urandom_range(12, (frame_q.size() < 20) ? frame_q.size() : 20);
      while (frame_q.size() > cut) void'(frame_q.pop_back());
    end
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    if (mismatches < MAX_PRINTS) $display("ERROR @%0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic cmp_field(input string name, input logic [19:0] got, input logic [19:0] want,
                           input logic [2:0] k);
    if (got !== want)
      report_mismatch($sformatf("kind %0d field %s: got %0h, want %0h", k, name, got, want));
  endtask

  // every result transfer is matched against the oldest pending record
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_recs.size() == 0) begin
        report_mismatch($sformatf("unexpected result transfer, kind %0d", out_data.kind));
      end else begin
        want_rec = pending_recs.pop_front();
        cmp_field("kind", out_data.kind, want_rec.kind, want_rec.kind);
        cmp_field("index", out_data.index, want_rec.index, want_rec.kind);
        cmp_field("x_cm", out_data.x_cm, want_rec.x_cm, want_rec.kind);
        cmp_field("y_cm", out_data.y_cm, want_rec.y_cm, want_rec.kind);
        cmp_field("aux_a", out_data.aux_a, want_rec.aux_a, want_rec.kind);
        cmp_field("aux_b", out_data.aux_b, want_rec.aux_b, want_rec.kind);
        cmp_field("distance_m", out_data.distance_m, want_rec.distance_m, want_rec.kind);
        cmp_field("speed_kmh_x10", out_data.speed_kmh_x10, want_rec.speed_kmh_x10,
                  want_rec.kind);
        cmp_field("eta_s", out_data.eta_s, want_rec.eta_s, want_rec.kind);
        cmp_field("remaining_m", out_data.remaining_m, want_rec.remaining_m, want_rec.kind);
        cmp_field("status", out_data.status, want_rec.status, want_rec.kind);
        cmp_field("last_of_run", out_data.last_of_run, want_rec.last_of_run, want_rec.kind);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result side: random stalls, calm stretches, and one long hold on request
  // ---------------------------------------------------------------------------
  initial begin : rx_drive
    int stall;
    int calm;
    int r;
    out_ready = 1'b0;
    stall = 0;
    calm = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        // long hold so the queue fills and the input side stalls
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (calm > 0) begin
        calm--;
        out_ready <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        r = $urandom_range(0, 99);
        if (r < 2) calm = $urandom_range(50, 200);
        else if (r < 30) stall = idle_len();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input side and configuration port
  // ---------------------------------------------------------------------------
  // offer one byte, wait for its transfer, log what it should cause, then idle;
  // a pinned status replaces the model's status record for directed rows
  task automatic push_byte(input logic [7:0] b, input logic fin, input bit pinned,
                           input logic [1:0] pin_stat);
    int n;
    int gap;
    int i;
    out_item_t st;
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, frame_end: fin};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (fin || (!prs_done && !(prs_badver && prs_sec != ST_HEADER))) live_items++;
    n = decode_byte(b, fin);
    st = '0;
    st.kind = KIND_STATUS;
    st.status = pin_stat;
    st.last_of_run = 1'b1;
    for (i = 0; i < n; i++) begin
      if (pinned && i == n - 1) pending_recs.push_back(st);
      else pending_recs.push_back(decoded[i]);
    end
    if (tx_calm > 0) begin
      tx_calm--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 149) == 0) tx_calm = $urandom_range(40, 150);
      gap = idle_len();
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // stop offering and wait until every owed record has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_recs.size() != 0) @(negedge clk);
  endtask

  task automatic reg_write(input logic sel, input logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= {24'd0, v};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (sel == REG_EXP_VERSION) cfg_version = v;
    else cfg_fallback = v;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic reg_check(input logic sel, input logic [7:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {sel, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[7:0] !== want)
      report_mismatch($sformatf("register %0d reads %0h, want %0h", sel, prdata[7:0], want));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // directed rows: byte, end mark, and a pinned status where it is obvious
  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
    logic       pinned;
    logic [1:0] stat;
  } dir_row_t;

  localparam int DIR_ROWS = 21;
  dir_row_t dir_tab [DIR_ROWS];

  initial begin : stimulus
    int ph;
    int goal;
    int half;
    int i;
    bit paused;
    logic [7:0] set_ver;
    logic [7:0] set_fb;

    dir_tab = '{
      '{8'h04, 1'b1, 1'b1, STAT_SHORT},    // lone version byte
      '{8'h00, 1'b0, 1'b0, STAT_OK},       // wrong version ...
      '{8'h00, 1'b1, 1'b1, STAT_SHORT},    // ... but too short wins
      '{8'h04, 1'b0, 1'b0, STAT_OK},       // version
      '{8'hFF, 1'b0, 1'b0, STAT_OK},       // flags, all set
      '{8'h10, 1'b0, 1'b0, STAT_OK},       // maneuver past the table, becomes straight
      '{8'hFF, 1'b0, 1'b0, STAT_OK},       // distance lo
      '{8'hFF, 1'b0, 1'b0, STAT_OK},       // distance hi
      '{8'h00, 1'b0, 1'b0, STAT_OK},       // speed lo
      '{8'h00, 1'b0, 1'b0, STAT_OK},       // speed hi
      '{8'hFF, 1'b0, 1'b0, STAT_OK},       // eta lo
      '{8'hFF, 1'b0, 1'b0, STAT_OK},       // eta hi
      '{8'hFF, 1'b0, 1'b0, STAT_OK},       // remaining lo
      '{8'hFF, 1'b0, 1'b0, STAT_OK},       // remaining hi, widest times ten
      '{8'h00, 1'b0, 1'b0, STAT_OK},       // no points, header record
      '{8'h00, 1'b0, 1'b0, STAT_OK},       // no landmarks
      '{8'h00, 1'b0, 1'b0, STAT_OK},       // no branches
      '{8'h00, 1'b0, 1'b0, STAT_OK},       // empty name completes the frame
      '{8'hA5, 1'b0, 1'b0, STAT_OK},       // trailing bytes are ignored
      '{8'h5A, 1'b1, 1'b1, STAT_OK},
      '{8'hFF, 1'b1, 1'b1, STAT_SHORT}     // widest version byte alone
    };

    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = 32'd0;
    hold_req   = 1'b0;
    mismatches = 0;
    live_items = 0;
    tx_calm    = 0;
    cfg_version  = EXP_VERSION_RST;
    cfg_fallback = 8'd0;
    clear_parse();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset values of both registers
    reg_check(REG_EXP_VERSION, EXP_VERSION_RST);
    reg_check(REG_FALLBACK_MRK, 8'd0);

    for (i = 0; i < DIR_ROWS; i++)
      push_byte(dir_tab[i].data_byte, dir_tab[i].frame_end, dir_tab[i].pinned,
                dir_tab[i].stat);

    // random phases, each under its own register setting; the first ones hit the extremes
    for (ph = 0; ph < 5; ph++) begin
      wait_drained();
      // a byte that causes no record may still be in flight
      repeat (10) @(negedge clk);
      case (ph)
        0: begin set_ver = 8'h00; set_fb = 8'hFF; end
        1: begin set_ver = 8'hFF; set_fb = 8'h00; end
        2: begin set_ver = EXP_VERSION_RST; set_fb = 8'h07; end
        default: begin set_ver = 8'($urandom); set_fb = 8'($urandom); end
      endcase
      reg_write(REG_EXP_VERSION, set_ver);
      reg_write(REG_FALLBACK_MRK, set_fb);
      reg_check(REG_EXP_VERSION, set_ver);
      reg_check(REG_FALLBACK_MRK, set_fb);

      goal = live_items + PHASE_ITEMS;
      half = live_items + PHASE_ITEMS / 2;
      paused = 1'b0;
      // receiver stops for a long while as this phase starts, sender keeps offering
      if (ph == 1) hold_req = 1'b1;
      while (live_items < goal) begin
        // once, let the block run dry in the middle of a phase
        if (ph == 3 && !paused && live_items >= half) begin
          wait_drained();
          @(negedge clk);
          paused = 1'b1;
        end
        build_frame();
        for (i = 0; i < frame_q.size(); i++)
          push_byte(frame_q[i], i == frame_q.size() - 1, 1'b0, STAT_OK);
      end
    end

    wait_drained();
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin : watchdog
    #15000000;
    $display("FAILURE");
    $finish;
  end

endmodule
